// ===== rtl/pscl_pkg.sv =====
// Package: shared types and constants of the per-source connection limiter.
package pscl_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;

	localparam logic [2:0] ST_ALLOWED  = 3'd0;
	localparam logic [2:0] ST_REFUSED  = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_UNKNOWN  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic OP_CONNECT    = 1'b0;
	localparam logic OP_DISCONNECT = 1'b1;

	localparam logic [2:0] REG_DEFAULT_LIMIT = 3'd0;
	localparam logic [2:0] REG_AK_ENABLE     = 3'd1;
	localparam logic [2:0] REG_MIN_INTERVAL  = 3'd2;
	localparam logic [2:0] REG_MAX_KILL      = 3'd3;
	localparam logic [2:0] REG_AK_DURATION   = 3'd4;

	// record layout: key, count, streak, last refusal time
	localparam int REC_W = 32 + 16 + 8 + 32;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] count;
		logic [7:0]  streak;
		logic [31:0] last_time;
	} rec_t;

	typedef struct packed {
		logic        op;
		logic [31:0] host_key;
		logic [31:0] now;
		logic        has_exception;
		logic [15:0] exception_limit;
	} in_beat_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  status;
		logic        ban_request;
		logic [31:0] ban_expiry;
		logic [15:0] count_after;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] default_limit;
		logic        autokill_enable;
		logic [31:0] min_kill_interval;
		logic [7:0]  max_kill_count;
		logic [31:0] autokill_duration;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;   // capture input beat
		logic clr_scan;  // restart scan
		logic step_scan; // advance scan index
		logic resolve;   // compute result and write back
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last; // current index is the last entry
	} sts_t;

endpackage

// ===== rtl/pscl_if.sv =====
// Interfaces: valid/ready stream channels and the config write channel.
interface pscl_in_if;
	logic                 valid;
	logic                 ready;
	pscl_pkg::in_beat_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pscl_out_if;
	logic                 valid;
	logic                 ready;
	pscl_pkg::out_beat_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pscl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/pscl_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module pscl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/pscl_dp.sv =====
// Datapath: table storage, key scan, and event resolution.
module pscl_dp #(
	parameter int TABLE_ENTRIES = pscl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pscl_pkg::cmd_t      cmd,
	output pscl_pkg::sts_t      sts,
	input  pscl_pkg::in_beat_t  in_data,
	input  pscl_pkg::cfg_t      cfg,
	output pscl_pkg::out_beat_t res
);
	localparam int IW = $clog2(TABLE_ENTRIES);

	pscl_pkg::in_beat_t ev_q;
	logic [IW-1:0]      idx_q;     // scan address
	logic [IW-1:0]      cmp_idx_q; // index of data now on rdata
	logic               cmp_vld_q;
	logic               hit_q, free_q;
	logic [IW-1:0]      hit_idx_q, free_idx_q;
	pscl_pkg::rec_t     hit_rec_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic                 we;
	logic [IW-1:0]        waddr;
	pscl_pkg::rec_t       wrec, rrec;
	logic [pscl_pkg::REC_W-1:0] rword;

	pscl_ram #(.WIDTH(pscl_pkg::REC_W), .DEPTH(TABLE_ENTRIES)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
		.raddr(idx_q), .rdata(rword)
	);
	assign rrec = pscl_pkg::rec_t'(rword);

	assign sts.scan_last = (cmp_idx_q == IW'(TABLE_ENTRIES - 1)) && cmp_vld_q;

	// scan: address runs one ahead of comparison
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; cmp_idx_q <= '0; cmp_vld_q <= 1'b0;
			hit_q <= 1'b0; free_q <= 1'b0;
		end else if (cmd.clr_scan) begin
			idx_q <= '0; cmp_vld_q <= 1'b0; hit_q <= 1'b0; free_q <= 1'b0;
		end else if (cmd.step_scan) begin
			if (idx_q != IW'(TABLE_ENTRIES - 1))
				idx_q <= idx_q + 1'b1;
			cmp_idx_q <= idx_q;
			cmp_vld_q <= 1'b1;
			if (cmp_vld_q) begin
				if (valid_q[cmp_idx_q] && rrec.key == ev_q.host_key && !hit_q)
					hit_q <= 1'b1;
				if (!valid_q[cmp_idx_q] && !free_q)
					free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			ev_q <= in_data;
		if (cmd.step_scan && cmp_vld_q) begin
			if (valid_q[cmp_idx_q] && rrec.key == ev_q.host_key && !hit_q) begin
				hit_idx_q <= cmp_idx_q;
				hit_rec_q <= rrec;
			end
			if (!valid_q[cmp_idx_q] && !free_q)
				free_idx_q <= cmp_idx_q;
		end
	end

	// resolution of the event against the found entry
	logic [15:0] limit;
	logic [32:0] edge_t;
	logic [7:0]  streak_inc;
	logic        fire_ban;
	logic        clear_v, set_v;

	always_comb begin
		res = '0;
		we = 1'b0;
		waddr = hit_idx_q;
		wrec = hit_rec_q;
		clear_v = 1'b0;
		set_v = 1'b0;
		limit = ev_q.has_exception ? ev_q.exception_limit : cfg.default_limit;
		edge_t = {1'b0, hit_rec_q.last_time} + {1'b0, cfg.min_kill_interval};
		streak_inc = (hit_rec_q.streak != 8'hFF) ? hit_rec_q.streak + 8'd1
			: hit_rec_q.streak;
		fire_ban = streak_inc >= cfg.max_kill_count;
		if (ev_q.op == pscl_pkg::OP_CONNECT) begin
			if (hit_q) begin
				if (limit != 16'd0 && hit_rec_q.count >= limit) begin
					res.status = pscl_pkg::ST_REFUSED;
					res.count_after = hit_rec_q.count;
					if (cfg.autokill_enable) begin
						we = 1'b1;
						wrec.last_time = ev_q.now;
						if ({1'b0, ev_q.now} <= edge_t) begin
							wrec.streak = streak_inc;
							if (fire_ban) begin
								res.ban_request = 1'b1;
								res.ban_expiry = ev_q.now + cfg.autokill_duration;
								wrec.streak = 8'd0;
							end
						end else
							wrec.streak = 8'd1;
					end
				end else begin
					we = 1'b1;
					if (hit_rec_q.count != 16'hFFFF)
						wrec.count = hit_rec_q.count + 16'd1;
					res.accepted = 1'b1;
					res.status = pscl_pkg::ST_ALLOWED;
					res.count_after = wrec.count;
				end
			end else begin
				res.accepted = 1'b1;
				if (free_q) begin
					we = 1'b1;
					set_v = 1'b1;
					waddr = free_idx_q;
					wrec.key = ev_q.host_key;
					wrec.count = 16'd1;
					wrec.streak = 8'd0;
					wrec.last_time = 32'd0;
					res.status = pscl_pkg::ST_ALLOWED;
					res.count_after = 16'd1;
				end else
					res.status = pscl_pkg::ST_FULL;
			end
		end else begin
			if (hit_q) begin
				res.status = pscl_pkg::ST_RELEASED;
				if (hit_rec_q.count > 16'd1) begin
					we = 1'b1;
					wrec.count = hit_rec_q.count - 16'd1;
					res.count_after = wrec.count;
				end else
					clear_v = 1'b1;
			end else
				res.status = pscl_pkg::ST_UNKNOWN;
		end
		if (!cmd.resolve) begin
			we = 1'b0; set_v = 1'b0; clear_v = 1'b0;
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (set_v)
			valid_q[free_idx_q] <= 1'b1;
		else if (clear_v)
			valid_q[hit_idx_q] <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve)
			assert (!(set_v && hit_q)) else $error("new entry made for a known key");
	end
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve |-> !cmd.step_scan) else $error("resolve during scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		set_v |=> valid_q[$past(free_idx_q)]) else $error("valid bit not set");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.resolve && res.ban_request) |-> !res.accepted)
		else $error("ban on an accepted connect");
endmodule

// ===== rtl/pscl_ctrl.sv =====
// Controller: sequences load, table scan, resolve and output handoff.
module pscl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_load,
	output pscl_pkg::cmd_t cmd,
	input  pscl_pkg::sts_t sts
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0] state_q;
	logic       ovld_q;

	assign out_valid = ovld_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load_in  = in_valid;
				cmd.clr_scan = in_valid;
			end
			S_SCAN: cmd.step_scan = 1'b1;
			S_RES: begin
				cmd.resolve = !ovld_q || out_ready;
				out_load = cmd.resolve;
			end
			S_HOLD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q <= 1'b0;
		end else begin
			if (out_load)
				ovld_q <= 1'b1;
			else if (out_ready)
				ovld_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_HOLD;
				S_HOLD: state_q <= S_RES;
				S_RES: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ovld_q) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !out_ready) |=> ovld_q) else $error("stalled result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_SCAN) else $error("scan not started");
endmodule

// ===== rtl/per_source_connection_limiter.sv =====
// Top level: per-source connection limiter with config registers.
// Usage:
//   in_ch  - connect/disconnect events (op, host_key, now, exception fields).
//   out_ch - one result beat per event (accepted, status, ban, count_after).
//   cfg_ch - register writes, index 0..4 as default_limit, autokill_enable,
//            min_kill_interval, max_kill_count, autokill_duration; other
//            indexes are ignored. Always ready. Write only while idle.
// Each event is handled alone: the key table lives in one RAM with one read
// port and is scanned one entry per cycle; an event goes from accept through
// the scan, a hold state and resolve to the result, and the next event is
// taken the cycle after the result is registered.
// The result sits in an output register; while the receiver stalls, the
// next event is accepted and scanned, waiting only to write its result.
// Reset empties the table at once through per-entry valid bits and loads
// the register defaults; no clearing pass is needed.
module per_source_connection_limiter #(
	parameter int TABLE_ENTRIES = pscl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pscl_in_if.sink    in_ch,
	pscl_out_if.source out_ch,
	pscl_cfg_if.sink   cfg_ch
);
	pscl_pkg::cfg_t      cfg_q;
	pscl_pkg::cmd_t      cmd;
	pscl_pkg::sts_t      sts;
	pscl_pkg::out_beat_t res;
	logic                out_load;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_limit     <= 16'd3;
			cfg_q.autokill_enable   <= 1'b0;
			cfg_q.min_kill_interval <= 32'd0;
			cfg_q.max_kill_count    <= 8'd5;
			cfg_q.autokill_duration <= 32'd1800;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				pscl_pkg::REG_DEFAULT_LIMIT: cfg_q.default_limit <= cfg_ch.wdata[15:0];
				pscl_pkg::REG_AK_ENABLE:     cfg_q.autokill_enable <= cfg_ch.wdata[0];
				pscl_pkg::REG_MIN_INTERVAL:  cfg_q.min_kill_interval <= cfg_ch.wdata;
				pscl_pkg::REG_MAX_KILL:      cfg_q.max_kill_count <= cfg_ch.wdata[7:0];
				pscl_pkg::REG_AK_DURATION:   cfg_q.autokill_duration <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

	pscl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_load(out_load), .cmd(cmd), .sts(sts)
	);

	pscl_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data(in_ch.data), .cfg(cfg_q), .res(res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (out_load)
			out_ch.data <= res;
	end
endmodule

// ===== tb/pscl_tb_pkg.sv =====
// Testbench package: stimulus row type for the connection limiter bench.
`timescale 1ns / 1ps
package pscl_tb_pkg;

	// one row of the directed table; has_exp marks a typed-in expectation
	typedef struct {
		pscl_pkg::in_beat_t  beat;
		logic                has_exp;
		pscl_pkg::out_beat_t exp;
	} drow_t;

endpackage

// ===== tb/per_source_connection_limiter_tb.sv =====
// Testbench top: drives connect/disconnect events and checks each result against a predictor.
`timescale 1ns / 1ps
module per_source_connection_limiter_tb;

	localparam int ENTRIES = 256;
	localparam int LATENCY = ENTRIES + 3;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fails;

	pscl_in_if  in_ch ();
	pscl_out_if out_ch ();
	pscl_cfg_if cfg_ch ();

	per_source_connection_limiter #(.TABLE_ENTRIES(ENTRIES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// limiter state as the bench sees it
	logic [15:0] lim_default;
	logic        ak_on;
	logic [31:0] ak_window;
	logic [7:0]  ak_max;
	logic [31:0] ak_duration;
	logic        tab_used [ENTRIES];
	logic [31:0] tab_key [ENTRIES];
	logic [15:0] tab_count [ENTRIES];
	logic [7:0]  tab_streak [ENTRIES];
	logic [31:0] tab_last [ENTRIES];

	pscl_pkg::out_beat_t verdict_q[$];
	int                  pending_typed[$];  // index into typed expectations or -1
	pscl_pkg::out_beat_t typed_q[$];

	logic quiet_rx;    // receiver never idles
	logic hold_rx;     // long receiver hold-off
	logic quiet_tx;
	int   idle_cycles;
	logic done_stim;

	function automatic void model_reset();
		lim_default = 16'd3;
		ak_on = 1'b0;
		ak_window = 32'd0;
		ak_max = 8'd5;
		ak_duration = 32'd1800;
		for (int i = 0; i < ENTRIES; i++) tab_used[i] = 1'b0;
	endfunction

	function automatic void model_config(logic [2:0] idx, logic [31:0] val);
		case (idx)
			pscl_pkg::REG_DEFAULT_LIMIT: lim_default = val[15:0];
			pscl_pkg::REG_AK_ENABLE:     ak_on = val[0];
			pscl_pkg::REG_MIN_INTERVAL:  ak_window = val;
			pscl_pkg::REG_MAX_KILL:      ak_max = val[7:0];
			pscl_pkg::REG_AK_DURATION:   ak_duration = val;
			default: ;
		endcase
	endfunction

	// work out the result of one event and update the table
	function automatic pscl_pkg::out_beat_t limit_event(pscl_pkg::in_beat_t b);
		pscl_pkg::out_beat_t r;
		int hit, slot;
		logic [15:0] lim;
		logic [32:0] edge_t;
		r = '0;
		hit = -1;
		slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (tab_used[i] && tab_key[i] == b.host_key) hit = i;
			if (!tab_used[i]) slot = i;
		end
		if (b.op == pscl_pkg::OP_CONNECT) begin
			if (hit >= 0) begin
				lim = b.has_exception ? b.exception_limit : lim_default;
				if (lim != 0 && tab_count[hit] >= lim) begin
					r.status = pscl_pkg::ST_REFUSED;
					if (ak_on) begin
						edge_t = {1'b0, tab_last[hit]} + {1'b0, ak_window};
						if ({1'b0, b.now} <= edge_t) begin
							if (tab_streak[hit] != 8'hff) tab_streak[hit]++;
							if (tab_streak[hit] >= ak_max) begin
								r.ban_request = 1'b1;
								r.ban_expiry = b.now + ak_duration;
								tab_streak[hit] = 8'd0;
							end
						end else begin
							tab_streak[hit] = 8'd1;
						end
						tab_last[hit] = b.now;
					end
					r.count_after = tab_count[hit];
				end else begin
					if (tab_count[hit] != 16'hffff) tab_count[hit]++;
					r.accepted = 1'b1;
					r.status = pscl_pkg::ST_ALLOWED;
					r.count_after = tab_count[hit];
				end
			end else begin
				r.accepted = 1'b1;
				if (slot >= 0) begin
					tab_used[slot] = 1'b1;
					tab_key[slot] = b.host_key;
					tab_count[slot] = 16'd1;
					tab_streak[slot] = 8'd0;
					tab_last[slot] = 32'd0;
					r.status = pscl_pkg::ST_ALLOWED;
					r.count_after = 16'd1;
				end else begin
					r.status = pscl_pkg::ST_FULL;
				end
			end
		end else if (hit >= 0) begin
			r.status = pscl_pkg::ST_RELEASED;
			if (tab_count[hit] > 1) begin
				tab_count[hit]--;
				r.count_after = tab_count[hit];
			end else begin
				tab_used[hit] = 1'b0;
			end
		end else begin
			r.status = pscl_pkg::ST_UNKNOWN;
		end
		return r;
	endfunction

	// send one event beat; predict at acceptance; valid drops only while idling
	task automatic send_event(pscl_pkg::in_beat_t b, logic typed, pscl_pkg::out_beat_t tv);
		while (!quiet_tx && $urandom_range(99) < 15) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		verdict_q.push_back(limit_event(b));
		if (typed) begin
			typed_q.push_back(tv);
			pending_typed.push_back(typed_q.size() - 1);
		end else begin
			pending_typed.push_back(-1);
		end
		@(negedge clk);
	endtask

	// stop offering and wait until every result is back
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		model_config(idx, val);
		@(negedge clk);
	endtask

	task automatic set_regs(logic [15:0] dl, logic ak, logic [31:0] win, logic [7:0] mk,
			logic [31:0] dur);
		wait_drained();
		write_reg(pscl_pkg::REG_DEFAULT_LIMIT, {16'd0, dl});
		write_reg(pscl_pkg::REG_AK_ENABLE, {31'd0, ak});
		write_reg(pscl_pkg::REG_MIN_INTERVAL, win);
		write_reg(pscl_pkg::REG_MAX_KILL, {24'd0, mk});
		write_reg(pscl_pkg::REG_AK_DURATION, dur);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic pscl_pkg::in_beat_t mk_beat(logic op, logic [31:0] key,
			logic [31:0] now, logic he, logic [15:0] el);
		pscl_pkg::in_beat_t b;
		b.op = op;
		b.host_key = key;
		b.now = now;
		b.has_exception = he;
		b.exception_limit = el;
		return b;
	endfunction

	function automatic pscl_pkg::out_beat_t mk_res(logic acc, logic [2:0] st,
			logic [15:0] cnt);
		pscl_pkg::out_beat_t r;
		r = '0;
		r.accepted = acc;
		r.status = st;
		r.count_after = cnt;
		return r;
	endfunction

	// receiver: random stalls, checks each result beat
	always @(negedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= !hold_rx && (quiet_rx || $urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		pscl_pkg::out_beat_t got, want;
		int ti;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				got = out_ch.data;
				want = verdict_q.pop_front();
				ti = pending_typed.pop_front();
				if (ti >= 0 && typed_q[ti] != want) begin
					$error("table row disagrees with predictor: table %h predictor %h",
						typed_q[ti], want);
					fails++;
				end
				if (got.accepted !== want.accepted) begin
					$error("accepted: expected %0d got %0d", want.accepted, got.accepted);
					fails++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d got %0d", want.status, got.status);
					fails++;
				end
				if (got.ban_request !== want.ban_request) begin
					$error("ban_request: expected %0d got %0d", want.ban_request,
						got.ban_request);
					fails++;
				end
				if (got.ban_expiry !== want.ban_expiry) begin
					$error("ban_expiry: expected %h got %h", want.ban_expiry, got.ban_expiry);
					fails++;
				end
				if (got.count_after !== want.count_after) begin
					$error("count_after: expected %0d got %0d", want.count_after,
						got.count_after);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| cfg_ch.valid || done_stim)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// pick a key from a small pool so entries fill and collide
	function automatic logic [31:0] pick_key(int pool);
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hffff_ffff;
			default: return 32'h5a00_0000 + $urandom_range(pool - 1);
		endcase
	endfunction

	// long receiver hold-off while events keep coming
	task automatic hold_receiver();
		int n;
		n = 0;
		hold_rx = 1'b1;
		while (n < 4 * LATENCY) begin
			@(negedge clk);
			n++;
		end
		hold_rx = 1'b0;
	endtask

	initial begin
		pscl_tb_pkg::drow_t rows[$];
		pscl_pkg::in_beat_t b;
		logic [31:0] t;
		int n_rand;
		done_stim = 1'b0;
		quiet_rx = 1'b0;
		quiet_tx = 1'b0;
		hold_rx = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		model_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset defaults, limit 3, unknown release, exceptions, extremes
		rows.push_back('{mk_beat(pscl_pkg::OP_DISCONNECT, 32'h0, 32'h0, 1'b0, 16'h0), 1'b1,
			mk_res(1'b0, pscl_pkg::ST_UNKNOWN, 16'd0)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h0, 1'b0, 16'h0), 1'b1,
			mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd1)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h0, 1'b0, 16'h0), 1'b1,
			mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd2)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h0, 1'b0, 16'h0), 1'b1,
			mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd3)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'hffff_ffff, 1'b0, 16'h0),
			1'b1, mk_res(1'b0, pscl_pkg::ST_REFUSED, 16'd3)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h1, 1'b1, 16'h0), 1'b1,
			mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd4)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h1, 1'b1, 16'hffff), 1'b1,
			mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd5)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'h0, 32'h1, 1'b1, 16'd2), 1'b1,
			mk_res(1'b0, pscl_pkg::ST_REFUSED, 16'd5)});
		rows.push_back('{mk_beat(pscl_pkg::OP_DISCONNECT, 32'hffff_ffff, 32'h0, 1'b1,
			16'hffff), 1'b1, mk_res(1'b0, pscl_pkg::ST_UNKNOWN, 16'd0)});
		rows.push_back('{mk_beat(pscl_pkg::OP_CONNECT, 32'hffff_ffff, 32'h0, 1'b1, 16'hffff),
			1'b1, mk_res(1'b1, pscl_pkg::ST_ALLOWED, 16'd1)});
		rows.push_back('{mk_beat(pscl_pkg::OP_DISCONNECT, 32'hffff_ffff, 32'h0, 1'b0, 16'h0),
			1'b1, mk_res(1'b0, pscl_pkg::ST_RELEASED, 16'd0)});
		rows.push_back('{mk_beat(pscl_pkg::OP_DISCONNECT, 32'h0, 32'h0, 1'b0, 16'h0), 1'b1,
			mk_res(1'b0, pscl_pkg::ST_RELEASED, 16'd4)});
		foreach (rows[i]) send_event(rows[i].beat, rows[i].has_exp, rows[i].exp);

		// autokill with a wide window and a short streak: ban and expiry wrap
		set_regs(16'd1, 1'b1, 32'hffff_ffff, 8'd2, 32'hffff_ffff);
		send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h77, 32'd0, 1'b0, 16'h0), 1'b0, '0);
		for (int i = 0; i < 5; i++)
			send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h77, 32'hffff_fff0 + i, 1'b0, 16'h0),
				1'b0, '0);
		// max kill count zero, zero window: refusals at and before the window edge
		set_regs(16'd1, 1'b1, 32'd0, 8'd0, 32'd10);
		send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h77, 32'd100, 1'b0, 16'h0), 1'b0, '0);
		send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h77, 32'd100, 1'b0, 16'h0), 1'b0, '0);
		send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h77, 32'd50, 1'b0, 16'h0), 1'b0, '0);

		// unlimited default, one key, no idling on either side
		set_regs(16'd0, 1'b0, 32'd0, 8'd1, 32'd0);
		quiet_tx = 1'b1;
		quiet_rx = 1'b1;
		for (int i = 0; i < 40; i++)
			send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h0001_0001, 32'd0, 1'b0, 16'h0),
				1'b0, '0);
		quiet_rx = 1'b0;
		quiet_tx = 1'b0;

		// table full: fill every free slot, then a new key is taken untracked
		for (int i = 0; i < ENTRIES + 2; i++)
			send_event(mk_beat(pscl_pkg::OP_CONNECT, 32'h00a0_0000 + i, 32'd0, 1'b0, 16'h0),
				1'b0, '0);
		for (int i = 0; i < ENTRIES; i++)
			send_event(mk_beat(pscl_pkg::OP_DISCONNECT, 32'h00a0_0000 + i, 32'd0, 1'b0,
				16'h0), 1'b0, '0);

		// random phases under several register settings
		n_rand = 0;
		t = $urandom();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(16'd3, 1'b1, 32'd5, 8'd3, 32'd1800);
				1: set_regs(16'd1, 1'b1, 32'hffff_ffff, 8'd255, $urandom());
				2: set_regs(16'hffff, 1'b0, $urandom(), 8'd1, $urandom());
				3: set_regs(16'($urandom_range(4)), 1'b1, $urandom_range(20),
					8'($urandom_range(6)), $urandom());
				4: set_regs(16'd2, 1'b1, 32'd0, 8'd1, 32'hffff_fff0);
				default: set_regs(16'd3, 1'b0, 32'd0, 8'd5, 32'd1800);
			endcase
			if (ph == 1) fork hold_receiver(); join_none
			if (ph == 2) quiet_rx = 1'b1;
			if (ph == 3) quiet_rx = 1'b0;
			for (int i = 0; i < 150; i++) begin
				t = t + $urandom_range(3);
				b.op = ($urandom_range(99) < 35) ? pscl_pkg::OP_DISCONNECT :
					pscl_pkg::OP_CONNECT;
				b.host_key = pick_key(ph == 4 ? 300 : 12);
				b.now = ($urandom_range(19) == 0) ? $urandom() : t;
				b.has_exception = ($urandom_range(3) == 0);
				b.exception_limit = ($urandom_range(3) == 0) ? 16'($urandom()) :
					16'($urandom_range(4));
				send_event(b, 1'b0, '0);
				n_rand++;
			end
			// pause the sender until everything has come back
			if (ph == 2) wait_drained();
		end

		// end of run
		wait_drained();
		done_stim = 1'b1;
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
